/* rtl/core/fht_pkg.sv */
// types, constants and butterfly helpers for the normalized hadamard frame transform
// no dependencies; used by the top level and fht_scale
package fht_pkg;

   localparam int CHANNELS    = 8;
   localparam int SAMPLE_BITS = 16;
   localparam int LANES       = 8;
   localparam int LANE_BITS   = $clog2(LANES);
   localparam int STAGES      = LANE_BITS;
   localparam int SUM_BITS    = SAMPLE_BITS + LANE_BITS + 1;
   localparam int SCALE_BITS  = 18;
   localparam int SCALE_SHIFT = 16;
   localparam int PROD_BITS   = SUM_BITS + SCALE_BITS;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;
   typedef logic signed [SCALE_BITS-1:0]  scale_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;

   typedef sample_type sample_frame_type [LANES];
   typedef sum_type    frame_type        [LANES];
   typedef prod_type   prod_frame_type   [LANES];

   // round(65536 / sqrt(n))
   function automatic scale_type scale_value(input int n);
      scale_type s;
      case (n)
         2:       s = scale_type'(46341);
         3:       s = scale_type'(37837);
         4:       s = scale_type'(32768);
         5:       s = scale_type'(29309);
         6:       s = scale_type'(26755);
         7:       s = scale_type'(24770);
         8:       s = scale_type'(23170);
         default: s = scale_type'(65536);
      endcase
      return s;
   endfunction

   localparam scale_type SCALE      = scale_value(CHANNELS);
   localparam prod_type  ROUND_HALF = prod_type'(64'sd1 <<< (SCALE_SHIFT - 1));
   localparam prod_type  MAX_VAL    = prod_type'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam prod_type  MIN_VAL    = prod_type'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   // one butterfly level in natural order; levels whose stride reaches the channel count pass through
   function automatic frame_type butterfly(input frame_type f, input int level);
      frame_type o;
      int stride;
      stride = 1 << level;
      for (int i = 0; i < LANES; i++) begin
         if (stride >= CHANNELS) begin
            o[i] = f[i];
         end else if ((i & stride) == 0) begin
            o[i] = f[i] + f[i | stride];
         end else begin
            o[i] = f[i ^ stride] - f[i];
         end
      end
      return o;
   endfunction

endpackage

/* rtl/core/fht_scale.sv */
// scaling back end: multiply by the normalization constant, round and saturate
// two register stages with valid/ready stall; depends on fht_pkg
module fht_scale (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  fht_pkg::frame_type       in_frame,
   output logic                     out_valid,
   input  logic                     out_ready,
   output fht_pkg::sample_frame_type out_result,
   output logic                     out_saturated
);

   logic                       prod_valid_ff;
   logic                       prod_valid_in;
   fht_pkg::prod_frame_type    prod_ff;
   fht_pkg::prod_frame_type    prod_in;
   logic                       res_valid_ff;
   logic                       res_valid_in;
   fht_pkg::sample_frame_type  res_ff;
   fht_pkg::sample_frame_type  res_in;
   logic                       sat_ff;
   logic                       sat_in;
   logic                       prod_ready;
   logic                       res_ready;
   fht_pkg::prod_type          rnd;

   assign res_ready  = !res_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || res_ready;
   assign in_ready   = prod_ready;

   assign prod_valid_in = prod_ready ? in_valid : prod_valid_ff;
   assign res_valid_in  = res_ready ? prod_valid_ff : res_valid_ff;

   always_comb begin
      for (int i = 0; i < fht_pkg::LANES; i++) begin
         prod_in[i] = fht_pkg::prod_type'(in_frame[i]) * fht_pkg::prod_type'(fht_pkg::SCALE);
      end
   end

   always_comb begin
      sat_in = 1'b0;
      rnd    = '0;
      for (int i = 0; i < fht_pkg::LANES; i++) begin
         rnd = (prod_ff[i] + fht_pkg::ROUND_HALF) >>> fht_pkg::SCALE_SHIFT;
         if (i >= fht_pkg::CHANNELS) begin
            res_in[i] = '0;
         end else if (rnd > fht_pkg::MAX_VAL) begin
            res_in[i] = fht_pkg::MAX_VAL[fht_pkg::SAMPLE_BITS-1:0];
            sat_in    = 1'b1;
         end else if (rnd < fht_pkg::MIN_VAL) begin
            res_in[i] = fht_pkg::MIN_VAL[fht_pkg::SAMPLE_BITS-1:0];
            sat_in    = 1'b1;
         end else begin
            res_in[i] = rnd[fht_pkg::SAMPLE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         res_valid_ff  <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && in_valid) begin
         prod_ff <= prod_in;
      end
      if (res_ready && prod_valid_ff) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid     = res_valid_ff;
   assign out_result    = res_ff;
   assign out_saturated = sat_ff;

endmodule

/* rtl/core/fast_hadamard_transform_frame_top.sv */
// normalized fast walsh-hadamard transform of one 8-lane sample frame per transaction
// every accepted request passes six registers on its way to rsp_valid:
//   input, 3 butterfly levels, multiply, round/saturate
// throughput: one frame per cycle while the response side takes results, every stage registered
// reset clears only the per-stage valid bits; data registers are not reset
// depends on fht_pkg and fht_scale
module fast_hadamard_transform_frame_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fht_pkg::sample_type req_sample_0,
   input  fht_pkg::sample_type req_sample_1,
   input  fht_pkg::sample_type req_sample_2,
   input  fht_pkg::sample_type req_sample_3,
   input  fht_pkg::sample_type req_sample_4,
   input  fht_pkg::sample_type req_sample_5,
   input  fht_pkg::sample_type req_sample_6,
   input  fht_pkg::sample_type req_sample_7,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fht_pkg::sample_type rsp_result_0,
   output fht_pkg::sample_type rsp_result_1,
   output fht_pkg::sample_type rsp_result_2,
   output fht_pkg::sample_type rsp_result_3,
   output fht_pkg::sample_type rsp_result_4,
   output fht_pkg::sample_type rsp_result_5,
   output fht_pkg::sample_type rsp_result_6,
   output fht_pkg::sample_type rsp_result_7,
   output logic                rsp_saturated
);

   localparam int NREG = fht_pkg::STAGES + 1;

   fht_pkg::sample_frame_type req_frame;
   fht_pkg::frame_type        in_frame;
   fht_pkg::frame_type        stage_ff    [NREG];
   fht_pkg::frame_type        stage_in    [NREG];
   logic [NREG-1:0]           valid_ff;
   logic [NREG-1:0]           valid_in;
   logic [NREG-1:0]           valid_src;
   logic [NREG:0]             ready;
   fht_pkg::sample_frame_type rsp_frame;

   assign req_frame[0] = req_sample_0;
   assign req_frame[1] = req_sample_1;
   assign req_frame[2] = req_sample_2;
   assign req_frame[3] = req_sample_3;
   assign req_frame[4] = req_sample_4;
   assign req_frame[5] = req_sample_5;
   assign req_frame[6] = req_sample_6;
   assign req_frame[7] = req_sample_7;

   // unused lanes enter the network as zero
   always_comb begin
      for (int i = 0; i < fht_pkg::LANES; i++) begin
         in_frame[i] = (i < fht_pkg::CHANNELS) ? fht_pkg::sum_type'(req_frame[i]) : '0;
      end
   end

   for (genvar k = 0; k < NREG; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign stage_in[k]  = in_frame;
         assign valid_src[k] = req_valid;
      end else begin : g_level
         assign stage_in[k]  = fht_pkg::butterfly(stage_ff[k-1], k - 1);
         assign valid_src[k] = valid_ff[k-1];
      end

      assign ready[k]    = !valid_ff[k] || ready[k+1];
      assign valid_in[k] = ready[k] ? valid_src[k] : valid_ff[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (ready[k] && valid_src[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign req_ready = ready[0];

   fht_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (valid_ff[NREG-1]),
      .in_ready      (ready[NREG]),
      .in_frame      (stage_ff[NREG-1]),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_result    (rsp_frame),
      .out_saturated (rsp_saturated)
   );

   assign rsp_result_0 = rsp_frame[0];
   assign rsp_result_1 = rsp_frame[1];
   assign rsp_result_2 = rsp_frame[2];
   assign rsp_result_3 = rsp_frame[3];
   assign rsp_result_4 = rsp_frame[4];
   assign rsp_result_5 = rsp_frame[5];
   assign rsp_result_6 = rsp_frame[6];
   assign rsp_result_7 = rsp_frame[7];

endmodule

/* rtl/core/fht_checker.sv */
// port-level checks for the hadamard frame transform, bound to the top level
// depends on fht_pkg and fast_hadamard_transform_frame_top
module fht_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input fht_pkg::sample_type rsp_result_0,
   input fht_pkg::sample_type rsp_result_1,
   input fht_pkg::sample_type rsp_result_2,
   input fht_pkg::sample_type rsp_result_3,
   input fht_pkg::sample_type rsp_result_4,
   input fht_pkg::sample_type rsp_result_5,
   input fht_pkg::sample_type rsp_result_6,
   input fht_pkg::sample_type rsp_result_7,
   input logic                rsp_saturated
);

   localparam fht_pkg::sample_type SMAX = fht_pkg::MAX_VAL[fht_pkg::SAMPLE_BITS-1:0];
   localparam fht_pkg::sample_type SMIN = fht_pkg::MIN_VAL[fht_pkg::SAMPLE_BITS-1:0];

   logic any_clip;

   assign any_clip = rsp_result_0 == SMAX || rsp_result_0 == SMIN ||
                     rsp_result_1 == SMAX || rsp_result_1 == SMIN ||
                     rsp_result_2 == SMAX || rsp_result_2 == SMIN ||
                     rsp_result_3 == SMAX || rsp_result_3 == SMIN ||
                     rsp_result_4 == SMAX || rsp_result_4 == SMIN ||
                     rsp_result_5 == SMAX || rsp_result_5 == SMIN ||
                     rsp_result_6 == SMAX || rsp_result_6 == SMIN ||
                     rsp_result_7 == SMAX || rsp_result_7 == SMIN;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // input stalls only when the output is full and held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without output backpressure");

   // saturation flag needs a clipped lane
   a_sat_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> any_clip)
      else $error("saturated set with no lane at a rail");

   // pending transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_0) &&
      $stable(rsp_result_7) && $stable(rsp_saturated))
      else $error("rsp transaction changed while stalled");

endmodule

bind fast_hadamard_transform_frame_top fht_checker u_fht_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_result_0  (rsp_result_0),
   .rsp_result_1  (rsp_result_1),
   .rsp_result_2  (rsp_result_2),
   .rsp_result_3  (rsp_result_3),
   .rsp_result_4  (rsp_result_4),
   .rsp_result_5  (rsp_result_5),
   .rsp_result_6  (rsp_result_6),
   .rsp_result_7  (rsp_result_7),
   .rsp_saturated (rsp_saturated)
);

/* dv/fast_hadamard_transform_frame_top_test.sv */
// self-checking testbench for fast_hadamard_transform_frame_top: directed and random frames,
// random idling on both channels, a long response hold-off, every result checked lane by lane
// depends on fht_pkg and the rtl top level
`timescale 1ns / 100ps

module fast_hadamard_transform_frame_top_test;

   localparam int LANES         = fht_pkg::LANES;
   localparam int SBITS         = fht_pkg::SAMPLE_BITS;
   localparam int SAMPLE_MAX    = (1 << (SBITS - 1)) - 1;
   localparam int SAMPLE_MIN    = -SAMPLE_MAX - 1;
   localparam int RANDOM_FRAMES = 1250;
   localparam int IDLE_PERCENT  = 7;
   localparam int CALM_FIRST    = 600;
   localparam int CALM_LAST     = 850;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 24;
   localparam int STALL_LIMIT   = 2000;
   localparam int PRINT_LIMIT   = 40;

   typedef logic [LANES-1:0][SBITS-1:0] sample_frame_type;

   typedef struct packed {
      sample_frame_type lanes;
      logic             saturated;
   } result_frame_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   fht_pkg::sample_type req_sample_0 = '0;
   fht_pkg::sample_type req_sample_1 = '0;
   fht_pkg::sample_type req_sample_2 = '0;
   fht_pkg::sample_type req_sample_3 = '0;
   fht_pkg::sample_type req_sample_4 = '0;
   fht_pkg::sample_type req_sample_5 = '0;
   fht_pkg::sample_type req_sample_6 = '0;
   fht_pkg::sample_type req_sample_7 = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   fht_pkg::sample_type rsp_result_0;
   fht_pkg::sample_type rsp_result_1;
   fht_pkg::sample_type rsp_result_2;
   fht_pkg::sample_type rsp_result_3;
   fht_pkg::sample_type rsp_result_4;
   fht_pkg::sample_type rsp_result_5;
   fht_pkg::sample_type rsp_result_6;
   fht_pkg::sample_type rsp_result_7;
   logic                rsp_saturated;

   sample_frame_type sample_frames_queued [$];
   result_frame_type transformed_frames_due [$];
   sample_frame_type frame_on_bus = '0;
   result_frame_type observed;
   result_frame_type wanted;
   int               frames_in = 0;
   int               frames_out = 0;
   int               hold_left = 0;
   bit               hold_done = 1'b0;
   int               stall_cycles = 0;
   int               mismatch_count = 0;

   fast_hadamard_transform_frame_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_0  (req_sample_0),
      .req_sample_1  (req_sample_1),
      .req_sample_2  (req_sample_2),
      .req_sample_3  (req_sample_3),
      .req_sample_4  (req_sample_4),
      .req_sample_5  (req_sample_5),
      .req_sample_6  (req_sample_6),
      .req_sample_7  (req_sample_7),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result_0  (rsp_result_0),
      .rsp_result_1  (rsp_result_1),
      .rsp_result_2  (rsp_result_2),
      .rsp_result_3  (rsp_result_3),
      .rsp_result_4  (rsp_result_4),
      .rsp_result_5  (rsp_result_5),
      .rsp_result_6  (rsp_result_6),
      .rsp_result_7  (rsp_result_7),
      .rsp_saturated (rsp_saturated)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // butterfly network, 1/sqrt(n) scale, round half up, clip
   function automatic result_frame_type hadamard_normalized(input sample_frame_type f);
      longint           lane [LANES];
      longint           a;
      longint           b;
      longint           scaled;
      longint           norm;
      int               chans;
      result_frame_type o;
      chans = fht_pkg::CHANNELS;
      case (chans)
         2:       norm = 46341;
         3:       norm = 37837;
         4:       norm = 32768;
         5:       norm = 29309;
         6:       norm = 26755;
         7:       norm = 24770;
         8:       norm = 23170;
         default: norm = 65536;
      endcase
      for (int i = 0; i < LANES; i++) begin
         lane[i] = (i < chans) ? longint'($signed(f[i])) : 64'sd0;
      end
      for (int stride = 1; stride < chans; stride = stride << 1) begin
         for (int i = 0; i < LANES; i++) begin
            if ((i & stride) == 0) begin
               a = lane[i];
               b = lane[i + stride];
               lane[i] = a + b;
               lane[i + stride] = a - b;
            end
         end
      end
      o.saturated = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         scaled = 0;
         if (i < chans) begin
            scaled = (lane[i] * norm + (64'sd1 <<< 15)) >>> 16;
            if (scaled > SAMPLE_MAX) begin
               scaled = SAMPLE_MAX;
               o.saturated = 1'b1;
            end else if (scaled < SAMPLE_MIN) begin
               scaled = SAMPLE_MIN;
               o.saturated = 1'b1;
            end
         end
         o.lanes[i] = fht_pkg::sample_type'(scaled);
      end
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            transformed_frames_due.push_back(hadamard_normalized(frame_on_bus));
            frames_in++;
         end
         if (!req_valid || req_ready) begin
            if (sample_frames_queued.size() != 0 &&
                ((frames_in >= CALM_FIRST && frames_in < CALM_LAST) ||
                 $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               frame_on_bus = sample_frames_queued.pop_front();
               req_sample_0 <= frame_on_bus[0];
               req_sample_1 <= frame_on_bus[1];
               req_sample_2 <= frame_on_bus[2];
               req_sample_3 <= frame_on_bus[3];
               req_sample_4 <= frame_on_bus[4];
               req_sample_5 <= frame_on_bus[5];
               req_sample_6 <= frame_on_bus[6];
               req_sample_7 <= frame_on_bus[7];
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and response side flow control
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            observed.lanes = {rsp_result_7, rsp_result_6, rsp_result_5, rsp_result_4,
                              rsp_result_3, rsp_result_2, rsp_result_1, rsp_result_0};
            observed.saturated = rsp_saturated;
            if (transformed_frames_due.size() == 0) begin
               report_mismatch($sformatf("result %0d with no frame outstanding", frames_out));
            end else begin
               wanted = transformed_frames_due.pop_front();
               for (int i = 0; i < LANES; i++) begin
                  if (observed.lanes[i] !== wanted.lanes[i]) begin
                     report_mismatch($sformatf("frame %0d result_%0d got %0d want %0d",
                                               frames_out, i, $signed(observed.lanes[i]),
                                               $signed(wanted.lanes[i])));
                  end
               end
               if (observed.saturated !== wanted.saturated) begin
                  report_mismatch($sformatf("frame %0d saturated got %b want %b",
                                            frames_out, observed.saturated,
                                            wanted.saturated));
               end
            end
            frames_out++;
         end
         // one long hold-off so the pipeline fills and stalls the request side
         if (!hold_done && frames_out >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (frames_out >= CALM_FIRST && frames_out < CALM_LAST) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      sample_frame_type f;
      int               kind;
      int               v;
      bit               up;
      int               total;

      // directed frames
      sample_frames_queued.push_back('0);
      sample_frames_queued.push_back({LANES{fht_pkg::sample_type'(SAMPLE_MAX)}});
      sample_frames_queued.push_back({LANES{fht_pkg::sample_type'(SAMPLE_MIN)}});
      for (int i = 0; i < LANES; i++) begin
         f[i] = (i % 2 == 0) ? fht_pkg::sample_type'(SAMPLE_MAX)
                             : fht_pkg::sample_type'(SAMPLE_MIN);
      end
      sample_frames_queued.push_back(f);
      sample_frames_queued.push_back(~f);
      for (int k = 0; k < LANES; k++) begin
         f = '0;
         f[k] = (k % 2 == 0) ? fht_pkg::sample_type'(SAMPLE_MAX)
                             : fht_pkg::sample_type'(SAMPLE_MIN);
         sample_frames_queued.push_back(f);
      end
      sample_frames_queued.push_back({LANES{fht_pkg::sample_type'(1)}});
      sample_frames_queued.push_back({LANES{fht_pkg::sample_type'(-1)}});
      f = {LANES{fht_pkg::sample_type'(SAMPLE_MAX)}};
      f[0] = fht_pkg::sample_type'(SAMPLE_MIN);
      sample_frames_queued.push_back(f);
      sample_frames_queued.push_back({(LANES / 2){16'h5555, 16'haaaa}});
      sample_frames_queued.push_back({(LANES / 2){16'h8001, 16'h7ffe}});

      // random frames: raw bits, extremes, small values, same-sign loud frames
      for (int n = 0; n < RANDOM_FRAMES; n++) begin
         kind = $urandom_range(0, 9);
         up = $urandom_range(0, 1);
         for (int i = 0; i < LANES; i++) begin
            case (kind)
               4, 5: begin
                  case ($urandom_range(0, 3))
                     0:       v = SAMPLE_MAX;
                     1:       v = SAMPLE_MIN;
                     2:       v = 0;
                     default: v = -1;
                  endcase
               end
               6, 7: v = $urandom_range(0, 512) - 256;
               8, 9: v = up ? $urandom_range(16384, SAMPLE_MAX)
                            : -$urandom_range(16384, -SAMPLE_MIN);
               default: v = $urandom;
            endcase
            f[i] = fht_pkg::sample_type'(v);
         end
         sample_frames_queued.push_back(f);
      end
      total = sample_frames_queued.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (frames_out < total) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && transformed_frames_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/fht_pkg.sv
rtl/core/fht_scale.sv
rtl/core/fast_hadamard_transform_frame_top.sv
rtl/core/fht_checker.sv
dv/fast_hadamard_transform_frame_top_test.sv
